/* src/bmf_pkg.sv */
package bmf_pkg;

   localparam int WINDOW_MAX   = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int CSR_W        = 6;
   localparam int WINDOW_RESET = 5;

   // store address / arrival tag width, and width that holds a size 0..WINDOW_MAX
   localparam int ADDR_W = $clog2(WINDOW_MAX);
   localparam int SIZE_W = $clog2(WINDOW_MAX + 1);

   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // one entry of the ordered store: arrival position within the block and value
   typedef struct packed {
      logic [ADDR_W-1:0]              tag;
      logic signed [SAMPLE_WIDTH-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_WALK,
      ST_INS_LAST,
      ST_SEL,
      ST_DONE
   } state_type;

endpackage

/* src/bmf_ram.sv */
module bmf_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/block_median_filter_top.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_command, req_sample
// rsp_      out        rsp_valid/rsp_ready    rsp_median_value, rsp_block_done, rsp_ready_flag
// csr_      in         csr_valid/csr_ready    csr_wdata (window_size)
//
// One item at a time. A restart goes from accept through ST_DONE to the result register.
// A push inserts its sample in order: the insertion walks the ordered
// store one entry per cycle through the single RAM read port. The push that
// completes a block adds a median search that scans the store in ascending order.
// Synchronous reset; no store clearing.
// req_ready stays high in idle even while a result waits on rsp_ready.
module block_median_filter_top
   import bmf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median_value,
   output logic                           rsp_block_done,
   output logic                           rsp_ready_flag,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_W-1:0]               csr_wdata
);

   // control state
   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  window_ff, window_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              ready_ff, ready_in;
   logic              sel_vld_ff, sel_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // item context and walk pointers
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic [ADDR_W-1:0]              tag_ff, tag_in;
   logic                           complete_ff, complete_in;
   logic [ADDR_W-1:0]              ptr_ff, ptr_in;
   logic [ADDR_W-1:0]              sel_ptr_ff, sel_ptr_in;
   logic [SIZE_W-1:0]              cnt_ff, cnt_in;
   logic signed [SAMPLE_WIDTH-1:0] med_ff, med_in;

   // result register
   logic signed [SAMPLE_WIDTH-1:0] rsp_med_ff, rsp_med_in;
   logic                           rsp_done_ff, rsp_done_in;
   logic                           rsp_rdy_ff, rsp_rdy_in;

   // RAM port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_data;

   // decode
   logic [SIZE_W-1:0] size_n;      // effective window size
   logic [SIZE_W-1:0] med_rank;    // rank of the median in the block
   logic              push_done;   // this push completes the block
   logic              push_ins;    // this push belongs to the ordered block
   logic              greater;     // walked entry lies above the new sample
   logic              tag_hit;     // walked entry belongs to the first size_n arrivals
   logic              out_free;
   logic              req_fire;

   assign rd_entry  = entry_type'(rd_data);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_med_ff;
   assign rsp_block_done   = rsp_done_ff;
   assign rsp_ready_flag   = rsp_rdy_ff;

   // zero acts as one, oversize clamps to the store depth
   always_comb begin
      if (window_ff == '0) begin
         size_n = SIZE_W'(1);
      end else if (int'(window_ff) > WINDOW_MAX) begin
         size_n = SIZE_W'(WINDOW_MAX);
      end else begin
         size_n = SIZE_W'(window_ff);
      end
   end

   assign med_rank  = size_n >> 1;
   assign push_done = (SIZE_W'(fill_ff) + SIZE_W'(1)) >= size_n;
   // after a mid-block shrink the completing sample is not among the first
   // size_n arrivals and stays out of the ordered store
   assign push_ins  = SIZE_W'(fill_ff) < size_n;
   assign greater   = rd_entry.value > x_ff;
   assign tag_hit   = SIZE_W'(rd_entry.tag) < size_n;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_command == CMD_RESTART) begin
                  state_in = ST_DONE;
               end else if (push_ins) begin
                  state_in = ST_INS_READ;
               end else begin
                  state_in = ST_SEL;
               end
            end
         end
         ST_INS_READ: begin
            if (tag_ff == '0) begin
               state_in = complete_ff ? ST_SEL : ST_DONE;
            end else begin
               state_in = ST_INS_WALK;
            end
         end
         ST_INS_WALK: begin
            if (!greater) begin
               state_in = complete_ff ? ST_SEL : ST_DONE;
            end else if (ptr_ff == '0) begin
               state_in = ST_INS_LAST;
            end
         end
         ST_INS_LAST: begin
            state_in = complete_ff ? ST_SEL : ST_DONE;
         end
         ST_SEL: begin
            if (sel_vld_ff && tag_hit && (cnt_ff == med_rank)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      ready_in     = ready_ff;
      x_in         = x_ff;
      tag_in       = tag_ff;
      complete_in  = complete_ff;
      ptr_in       = ptr_ff;
      sel_ptr_in   = '0;
      sel_vld_in   = 1'b0;
      cnt_in       = '0;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_med_in   = rsp_med_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_rdy_in   = rsp_rdy_ff;

      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_entry.tag   = tag_ff;
      wr_entry.value = x_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;

      if (csr_valid && csr_ready) begin
         window_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in   = req_sample;
               tag_in = fill_ff;
               med_in = '0;
               if (req_command == CMD_RESTART) begin
                  fill_in     = '0;
                  ready_in    = 1'b0;
                  complete_in = 1'b0;
               end else begin
                  complete_in = push_done;
                  ready_in    = push_done;
                  fill_in     = push_done ? '0 : fill_ff + ADDR_W'(1);
               end
            end
         end
         ST_INS_READ: begin
            // store holds tag_ff entries; empty store takes the sample at once
            if (tag_ff == '0) begin
               wr_en   = 1'b1;
               wr_addr = '0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = tag_ff - ADDR_W'(1);
               ptr_in  = tag_ff - ADDR_W'(1);
            end
         end
         ST_INS_WALK: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + ADDR_W'(1);
            if (greater) begin
               // shift entry up one place, keep walking down
               wr_entry = rd_entry;
               if (ptr_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - ADDR_W'(1);
                  ptr_in  = ptr_ff - ADDR_W'(1);
               end
            end
         end
         ST_INS_LAST: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         ST_SEL: begin
            // scan ascending, counting only entries of the first size_n arrivals
            rd_en      = 1'b1;
            rd_addr    = sel_ptr_ff;
            sel_ptr_in = sel_ptr_ff + ADDR_W'(1);
            sel_vld_in = 1'b1;
            cnt_in     = cnt_ff;
            if (sel_vld_ff && tag_hit) begin
               if (cnt_ff == med_rank) begin
                  med_in     = rd_entry.value;
                  sel_vld_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + SIZE_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = med_ff;
               rsp_done_in  = complete_ff;
               rsp_rdy_in   = ready_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= CSR_W'(WINDOW_RESET);
         fill_ff      <= '0;
         ready_ff     <= 1'b0;
         sel_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         sel_vld_ff   <= sel_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      tag_ff      <= tag_in;
      complete_ff <= complete_in;
      ptr_ff      <= ptr_in;
      sel_ptr_ff  <= sel_ptr_in;
      cnt_ff      <= cnt_in;
      med_ff      <= med_in;
      rsp_med_ff  <= rsp_med_in;
      rsp_done_ff <= rsp_done_in;
      rsp_rdy_ff  <= rsp_rdy_in;
   end

   // ordered sample store
   bmf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
